### rtl/core/pt6_pkg.sv
`default_nettype none
package pt6_pkg;

  // spacing between tuple members and the first trial divisor of the 6k-1 / 6k+1 walk
  localparam int unsigned STEP_GAP  = 6;
  localparam int unsigned FIRST_DIV = 5;
  localparam int unsigned SECOND_DIV_OFS = 2;
  localparam int unsigned THIRD_DIV = 3;
  localparam int unsigned SMALL_PRIME_MAX = 3;

  // configuration register indexes
  localparam logic REG_UPPER_LIMIT  = 1'b0;
  localparam logic REG_TUPLE_LENGTH = 1'b1;

  localparam int unsigned LIMIT_BITS  = 24;
  localparam int unsigned LENGTH_BITS = 4;
  localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 24'hFFFFFF;
  localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 4'd2;

  // remainder unit status back to the sequencer
  typedef struct packed {
    logic done;   // one-cycle pulse when the remainder is ready
    logic zero;   // remainder is zero, valid with done
  } div_status_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MEMBER = 7'b0000010,
    S_WAIT3  = 7'b0000100,
    S_LOOP   = 7'b0001000,
    S_WAITD  = 7'b0010000,
    S_WAITD2 = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

### rtl/core/prime_tuple_step_six_checker_unit.sv
// A candidate over the limit or with zero length is dropped in its accept cycle; a member
// of 0 or 1, or an even member above 3, ends the test without the remainder unit. Each odd member
// above 3 is checked by 3, then by each 6k-1/6k+1 divisor pair up to sqrt(member). Emission
// sends one member per cycle while member_ready is high.
// One candidate is in work at a time: a new candidate is taken only while the sequencer is idle.
// Reset (rst, synchronous, active high): upper_limit all ones, tuple_length 2, sequencer idle.
`default_nettype none
module prime_tuple_step_six_checker_unit #(
  parameter int unsigned VALUE_BITS = 24,
  parameter int unsigned MAX_TUPLE  = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write port
  input  wire logic                           wr_en,
  input  wire logic                           wr_index,
  input  wire logic [pt6_pkg::LIMIT_BITS-1:0] wr_data,
  // candidate channel
  input  wire logic                           candidate_valid,
  output logic                                candidate_ready,
  input  wire logic [VALUE_BITS-1:0]          candidate,
  // member channel
  output logic                                member_valid,
  input  wire logic                           member_ready,
  output logic [VALUE_BITS:0]                 member,
  output logic [$clog2(MAX_TUPLE)-1:0]        position,
  output logic                                last
);

  // member values carry one extra bit for start + 6 * position
  localparam int unsigned W    = VALUE_BITS + 1;
  localparam int unsigned SW   = W + 1;
  localparam int unsigned PW   = $clog2(MAX_TUPLE);
  localparam int unsigned CW   = $clog2(MAX_TUPLE + 1);
  localparam int unsigned CMPW = (VALUE_BITS > pt6_pkg::LIMIT_BITS) ?
                                 VALUE_BITS : pt6_pkg::LIMIT_BITS;

  // configuration registers
  logic [pt6_pkg::LIMIT_BITS-1:0]  upper_limit;
  logic [pt6_pkg::LENGTH_BITS-1:0] tuple_length;

  // sequencer registers
  pt6_pkg::state_t state, state_next;
  logic [W-1:0]    start_val, start_val_next;   // candidate of the item in work
  logic [W-1:0]    value, value_next;           // member under test / being sent
  logic [PW-1:0]   k, k_next;                   // member position
  logic [CW-1:0]   count, count_next;           // members to test, saturated
  logic [W-1:0]    dval, dval_next;             // trial divisor base 6k-1
  logic [SW-1:0]   sq, sq_next;                 // dval squared, kept by increments
  logic [W-1:0]    divisor, divisor_next;       // operand handed to the remainder unit
  logic            div_go, div_go_next;

  pt6_pkg::div_status_t div_status;

  logic [CW-1:0]   count_sat;
  logic            over_limit;
  logic            member_ok;
  logic            is_last;

  // user must do config writes only while idle, unchecked; 1-bit index has no unknown value
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit  <= pt6_pkg::LIMIT_RESET;
      tuple_length <= pt6_pkg::LENGTH_RESET;
    end else if (wr_en) begin
      if (wr_index == pt6_pkg::REG_UPPER_LIMIT) begin
        upper_limit <= wr_data;
      end else begin
        tuple_length <= wr_data[pt6_pkg::LENGTH_BITS-1:0];
      end
    end
  end

  // shared remainder unit: every trial divisor (3, 6k-1, 6k+1) goes through it
  pt6_rem #(
    .W (W)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (value),
    .divisor  (divisor),
    .status   (div_status)
  );

  always_comb begin
    if (32'(tuple_length) > MAX_TUPLE) begin
      count_sat = CW'(MAX_TUPLE);
    end else begin
      count_sat = CW'(tuple_length);
    end
    over_limit = CMPW'(candidate) > CMPW'(upper_limit);
    is_last    = (CW'(k) + CW'(1)) == count;
  end

  always_comb begin
    state_next     = state;
    start_val_next = start_val;
    value_next     = value;
    k_next         = k;
    count_next     = count;
    dval_next      = dval;
    sq_next        = sq;
    divisor_next   = divisor;
    div_go_next    = 1'b0;
    member_ok      = 1'b0;

    unique case (state)
      pt6_pkg::S_IDLE: begin
        // take a transfer; drop it at once when it cannot produce a tuple
        if (candidate_valid) begin
          start_val_next = W'(candidate);
          value_next     = W'(candidate);
          k_next         = '0;
          count_next     = count_sat;
          if (count_sat != '0 && !over_limit) begin
            state_next = pt6_pkg::S_MEMBER;
          end
        end
      end
      pt6_pkg::S_MEMBER: begin
        // small values and even values settle without the divider
        if (value <= W'(pt6_pkg::SMALL_PRIME_MAX)) begin
          if (value > W'(1)) begin
            member_ok = 1'b1;
          end else begin
            state_next = pt6_pkg::S_IDLE;
          end
        end else if (!value[0]) begin
          state_next = pt6_pkg::S_IDLE;
        end else begin
          divisor_next = W'(pt6_pkg::THIRD_DIV);
          div_go_next  = 1'b1;
          state_next   = pt6_pkg::S_WAIT3;
        end
      end
      pt6_pkg::S_WAIT3: begin
        if (div_status.done) begin
          if (div_status.zero) begin
            state_next = pt6_pkg::S_IDLE;
          end else begin
            dval_next  = W'(pt6_pkg::FIRST_DIV);
            sq_next    = SW'(pt6_pkg::FIRST_DIV * pt6_pkg::FIRST_DIV);
            state_next = pt6_pkg::S_LOOP;
          end
        end
      end
      pt6_pkg::S_LOOP: begin
        // stop once the divisor square passes the value
        if (sq > SW'(value)) begin
          member_ok = 1'b1;
        end else begin
          divisor_next = dval;
          div_go_next  = 1'b1;
          state_next   = pt6_pkg::S_WAITD;
        end
      end
      pt6_pkg::S_WAITD: begin
        if (div_status.done) begin
          if (div_status.zero) begin
            state_next = pt6_pkg::S_IDLE;
          end else begin
            divisor_next = dval + W'(pt6_pkg::SECOND_DIV_OFS);
            div_go_next  = 1'b1;
            state_next   = pt6_pkg::S_WAITD2;
          end
        end
      end
      pt6_pkg::S_WAITD2: begin
        if (div_status.done) begin
          if (div_status.zero) begin
            state_next = pt6_pkg::S_IDLE;
          end else begin
            // (d+6)^2 = d^2 + 12d + 36
            dval_next  = dval + W'(pt6_pkg::STEP_GAP);
            sq_next    = sq + SW'(SW'(dval) * SW'(2 * pt6_pkg::STEP_GAP))
                         + SW'(pt6_pkg::STEP_GAP * pt6_pkg::STEP_GAP);
            state_next = pt6_pkg::S_LOOP;
          end
        end
      end
      pt6_pkg::S_EMIT: begin
        // advance one member per output transfer
        if (member_ready) begin
          if (is_last) begin
            state_next = pt6_pkg::S_IDLE;
          end else begin
            k_next     = k + PW'(1);
            value_next = value + W'(pt6_pkg::STEP_GAP);
          end
        end
      end
      default: begin
        state_next = pt6_pkg::S_IDLE;
      end
    endcase

    // member proved prime: test the next one, or rewind and start sending
    if (member_ok) begin
      if (is_last) begin
        value_next = start_val;
        k_next     = '0;
        state_next = pt6_pkg::S_EMIT;
      end else begin
        k_next     = k + PW'(1);
        value_next = value + W'(pt6_pkg::STEP_GAP);
        state_next = pt6_pkg::S_MEMBER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pt6_pkg::S_IDLE;
      div_go <= 1'b0;
    end else begin
      state  <= state_next;
      div_go <= div_go_next;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    start_val <= start_val_next;
    value     <= value_next;
    k         <= k_next;
    count     <= count_next;
    dval      <= dval_next;
    sq        <= sq_next;
    divisor   <= divisor_next;
  end

  assign candidate_ready = (state == pt6_pkg::S_IDLE);
  assign member_valid    = (state == pt6_pkg::S_EMIT);
  assign member          = value;
  assign position        = k;
  assign last            = is_last;

endmodule
`default_nettype wire

### rtl/core/pt6_rem.sv
`default_nettype none
// Restoring remainder unit, one quotient bit per cycle.
module pt6_rem #(
  parameter int unsigned W = 25
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [W-1:0]      dividend,
  input  wire logic [W-1:0]      divisor,
  output pt6_pkg::div_status_t   status
);

  localparam int unsigned CNTW = $clog2(W + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [W-1:0]    dvd;
  logic [W-1:0]    dsr;
  logic [W-1:0]    rem;
  logic            done;
  logic            zero;

  logic [W:0]      trial;
  logic [W-1:0]    rem_step;

  always_comb begin
    trial = {rem, dvd[W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_step = W'(trial - {1'b0, dsr});
    end else begin
      rem_step = trial[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(W);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      dvd  <= {dvd[W-2:0], 1'b0};
      rem  <= rem_step;
      zero <= (rem_step == '0);
    end
  end

  assign status.done = done;
  assign status.zero = zero;

endmodule
`default_nettype wire
